// ===== design/rbu_pkg.sv =====
package rbu_pkg;

   localparam int CH_BITS = 8;
   localparam int NUM_CH = 4;
   localparam int ALPHA_CH = 3;
   localparam logic [CH_BITS-1:0] CH_MAX = 8'd255;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RGB_EQUATION     = 3'd0,
      CSR_ALPHA_EQUATION   = 3'd1,
      CSR_SRC_RGB_FACTOR   = 3'd2,
      CSR_SRC_ALPHA_FACTOR = 3'd3,
      CSR_DST_RGB_FACTOR   = 3'd4,
      CSR_DST_ALPHA_FACTOR = 3'd5,
      CSR_BLEND_CONSTANT   = 3'd6,
      CSR_CHANNEL_ENABLES  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      EQ_ADD  = 2'd0,
      EQ_SUB  = 2'd1,
      EQ_RSUB = 2'd2
   } equation_type;

   typedef enum logic [3:0] {
      FACTOR_ZERO               = 4'd0,
      FACTOR_ONE                = 4'd1,
      FACTOR_SRC_COLOR          = 4'd2,
      FACTOR_ONE_MINUS_SRC      = 4'd3,
      FACTOR_DST_COLOR          = 4'd4,
      FACTOR_ONE_MINUS_DST      = 4'd5,
      FACTOR_SRC_ALPHA          = 4'd6,
      FACTOR_ONE_MINUS_SRC_A    = 4'd7,
      FACTOR_DST_ALPHA          = 4'd8,
      FACTOR_ONE_MINUS_DST_A    = 4'd9,
      FACTOR_CONST_COLOR        = 4'd10,
      FACTOR_ONE_MINUS_CONST    = 4'd11,
      FACTOR_CONST_ALPHA        = 4'd12,
      FACTOR_ONE_MINUS_CONST_A  = 4'd13,
      FACTOR_SRC_ALPHA_SATURATE = 4'd14
   } factor_type;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_SUB  = 2'd1,
      OP_RSUB = 2'd2,
      OP_KEEP = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]            rgb_equation;
      logic [1:0]            alpha_equation;
      logic [3:0]            src_rgb_factor;
      logic [3:0]            src_alpha_factor;
      logic [3:0]            dst_rgb_factor;
      logic [3:0]            dst_alpha_factor;
      logic [CSR_DATA_W-1:0] blend_constant;
      logic [NUM_CH-1:0]     channel_enables;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rgb_equation:     2'd0,
      alpha_equation:   2'd0,
      src_rgb_factor:   4'd1,
      src_alpha_factor: 4'd1,
      dst_rgb_factor:   4'd0,
      dst_alpha_factor: 4'd0,
      blend_constant:   32'd0,
      channel_enables:  4'hF
   };

   typedef struct packed {
      logic [CH_BITS-1:0] src;
      logic [CH_BITS-1:0] dst;
      logic [CH_BITS-1:0] sf;
      logic [CH_BITS-1:0] df;
      op_type             op;
   } chan_work_type;

   typedef struct packed {
      chan_work_type [NUM_CH-1:0] chan;
      logic [CH_BITS-1:0]         mask;
      logic                       last;
   } work_type;

   typedef struct packed {
      logic [CH_BITS-1:0] dst;
      logic [2*CH_BITS-1:0] sp;
      logic [2*CH_BITS-1:0] dp;
      op_type             op;
   } chan_prod_type;

   typedef struct packed {
      chan_prod_type [NUM_CH-1:0] chan;
      logic [CH_BITS-1:0]         mask;
      logic                       last;
   } prod_type;

   typedef struct packed {
      logic [NUM_CH-1:0][CH_BITS-1:0] color;
      logic                           last;
   } rsp_type;

   function automatic logic [CH_BITS-1:0] pick_factor(
      input logic [3:0]         mode,
      input logic               is_alpha,
      input logic [CH_BITS-1:0] s,
      input logic [CH_BITS-1:0] d,
      input logic [CH_BITS-1:0] k,
      input logic [CH_BITS-1:0] sa,
      input logic [CH_BITS-1:0] da,
      input logic [CH_BITS-1:0] ka
   );
      logic [CH_BITS-1:0] inv;
      logic [CH_BITS-1:0] f;
      inv = CH_MAX - da;
      unique case (mode)
         FACTOR_ZERO:               f = '0;
         FACTOR_ONE:                f = CH_MAX;
         FACTOR_SRC_COLOR:          f = s;
         FACTOR_ONE_MINUS_SRC:      f = CH_MAX - s;
         FACTOR_DST_COLOR:          f = d;
         FACTOR_ONE_MINUS_DST:      f = CH_MAX - d;
         FACTOR_SRC_ALPHA:          f = sa;
         FACTOR_ONE_MINUS_SRC_A:    f = CH_MAX - sa;
         FACTOR_DST_ALPHA:          f = da;
         FACTOR_ONE_MINUS_DST_A:    f = CH_MAX - da;
         FACTOR_CONST_COLOR:        f = k;
         FACTOR_ONE_MINUS_CONST:    f = CH_MAX - k;
         FACTOR_CONST_ALPHA:        f = ka;
         FACTOR_ONE_MINUS_CONST_A:  f = CH_MAX - ka;
         FACTOR_SRC_ALPHA_SATURATE: f = is_alpha ? CH_MAX : ((inv < sa) ? inv : sa);
         default:                   f = '0;
      endcase
      return f;
   endfunction

endpackage

// ===== design/rbu_front.sv =====
module rbu_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rbu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rbu_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [rbu_pkg::CH_BITS-1:0]         write_mask,
   input  logic [rbu_pkg::NUM_CH-1:0][rbu_pkg::CH_BITS-1:0] src,
   input  logic [rbu_pkg::NUM_CH-1:0][rbu_pkg::CH_BITS-1:0] dst,
   input  logic                                last_in,
   output rbu_pkg::work_type                   work
);

   rbu_pkg::cfg_type cfg_ff;
   rbu_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rbu_pkg::CSR_RGB_EQUATION:     cfg_in.rgb_equation = csr_data[1:0];
            rbu_pkg::CSR_ALPHA_EQUATION:   cfg_in.alpha_equation = csr_data[1:0];
            rbu_pkg::CSR_SRC_RGB_FACTOR:   cfg_in.src_rgb_factor = csr_data[3:0];
            rbu_pkg::CSR_SRC_ALPHA_FACTOR: cfg_in.src_alpha_factor = csr_data[3:0];
            rbu_pkg::CSR_DST_RGB_FACTOR:   cfg_in.dst_rgb_factor = csr_data[3:0];
            rbu_pkg::CSR_DST_ALPHA_FACTOR: cfg_in.dst_alpha_factor = csr_data[3:0];
            rbu_pkg::CSR_BLEND_CONSTANT:   cfg_in.blend_constant = csr_data;
            rbu_pkg::CSR_CHANNEL_ENABLES:  cfg_in.channel_enables = csr_data[3:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rbu_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify each channel: pick factors and the operation
   always_comb begin
      logic               is_alpha;
      logic [1:0]         eq;
      logic [3:0]         src_mode;
      logic [3:0]         dst_mode;
      logic [rbu_pkg::CH_BITS-1:0] k [rbu_pkg::NUM_CH];
      for (int ch = 0; ch < rbu_pkg::NUM_CH; ch++) begin
         k[ch] = cfg_ff.blend_constant[ch*rbu_pkg::CH_BITS +: rbu_pkg::CH_BITS];
      end
      work.mask = write_mask;
      work.last = last_in;
      for (int ch = 0; ch < rbu_pkg::NUM_CH; ch++) begin
         is_alpha = (ch == rbu_pkg::ALPHA_CH);
         eq       = is_alpha ? cfg_ff.alpha_equation : cfg_ff.rgb_equation;
         src_mode = is_alpha ? cfg_ff.src_alpha_factor : cfg_ff.src_rgb_factor;
         dst_mode = is_alpha ? cfg_ff.dst_alpha_factor : cfg_ff.dst_rgb_factor;
         work.chan[ch].src = src[ch];
         work.chan[ch].dst = dst[ch];
         work.chan[ch].sf  = rbu_pkg::pick_factor(src_mode, is_alpha, src[ch], dst[ch], k[ch],
            src[rbu_pkg::ALPHA_CH], dst[rbu_pkg::ALPHA_CH], k[rbu_pkg::ALPHA_CH]);
         work.chan[ch].df  = rbu_pkg::pick_factor(dst_mode, is_alpha, src[ch], dst[ch], k[ch],
            src[rbu_pkg::ALPHA_CH], dst[rbu_pkg::ALPHA_CH], k[rbu_pkg::ALPHA_CH]);
         if (!cfg_ff.channel_enables[ch]) begin
            work.chan[ch].op = rbu_pkg::OP_KEEP;
         end else begin
            unique case (eq)
               rbu_pkg::EQ_ADD:  work.chan[ch].op = rbu_pkg::OP_ADD;
               rbu_pkg::EQ_SUB:  work.chan[ch].op = rbu_pkg::OP_SUB;
               rbu_pkg::EQ_RSUB: work.chan[ch].op = rbu_pkg::OP_RSUB;
               default:          work.chan[ch].op = rbu_pkg::OP_KEEP;
            endcase
         end
      end
   end

endmodule

// ===== design/rbu_queue.sv =====
module rbu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rbu_pkg::work_type push_data,
   output logic              full,
   output logic              valid,
   input  logic              pop,
   output rbu_pkg::work_type pop_data
);

   rbu_pkg::work_type entry_ff [rbu_pkg::QUEUE_DEPTH];
   logic [rbu_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rbu_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rbu_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full     = (count_ff == rbu_pkg::QUEUE_CNT_W'(rbu_pkg::QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/rbu_back.sv =====
module rbu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              work_valid,
   input  rbu_pkg::work_type work,
   output logic              work_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rbu_pkg::rsp_type  rsp
);

   localparam int PW = 2 * rbu_pkg::CH_BITS;

   rbu_pkg::prod_type prod_ff, prod_in;
   logic              prod_valid_ff, prod_valid_in;
   logic              prod_ready;

   rbu_pkg::rsp_type  out_ff [rbu_pkg::QUEUE_DEPTH];
   rbu_pkg::rsp_type  result;
   logic [rbu_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rbu_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rbu_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic out_push, out_pop, out_room;

   assign out_pop    = rsp_pop && (count_ff != '0);
   assign out_room   = (count_ff != rbu_pkg::QUEUE_CNT_W'(rbu_pkg::QUEUE_DEPTH)) || out_pop;
   assign out_push   = prod_valid_ff && out_room;
   assign prod_ready = !prod_valid_ff || out_room;
   assign work_pop   = work_valid && prod_ready;
   assign rsp_empty  = (count_ff == '0);
   assign rsp        = out_ff[rd_ptr_ff];

   // multiply stage
   always_comb begin
      prod_in.mask = work.mask;
      prod_in.last = work.last;
      for (int ch = 0; ch < rbu_pkg::NUM_CH; ch++) begin
         prod_in.chan[ch].dst = work.chan[ch].dst;
         prod_in.chan[ch].op  = work.chan[ch].op;
         prod_in.chan[ch].sp  = PW'(work.chan[ch].src) * PW'(work.chan[ch].sf);
         prod_in.chan[ch].dp  = PW'(work.chan[ch].dst) * PW'(work.chan[ch].df);
      end
      if (work_pop) begin
         prod_valid_in = 1'b1;
      end else if (out_push) begin
         prod_valid_in = 1'b0;
      end else begin
         prod_valid_in = prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_pop) begin
         prod_ff <= prod_in;
      end
   end

   // combine, divide by 255, saturate, apply mask
   always_comb begin
      logic [PW:0]   sp, dp, x;
      logic [PW+1:0] t;
      logic [rbu_pkg::CH_BITS+1:0] q;
      logic [rbu_pkg::CH_BITS-1:0] sat, blend, d;
      result.last = prod_ff.last;
      for (int ch = 0; ch < rbu_pkg::NUM_CH; ch++) begin
         sp = {1'b0, prod_ff.chan[ch].sp};
         dp = {1'b0, prod_ff.chan[ch].dp};
         d  = prod_ff.chan[ch].dst;
         case (prod_ff.chan[ch].op)
            rbu_pkg::OP_ADD:  x = sp + dp;
            rbu_pkg::OP_SUB:  x = (sp > dp) ? sp - dp : '0;
            rbu_pkg::OP_RSUB: x = (dp > sp) ? dp - sp : '0;
            default:          x = '0;
         endcase
         t     = (PW+2)'(x) + (PW+2)'(1) + (PW+2)'(x >> rbu_pkg::CH_BITS);
         q     = t[PW+1:rbu_pkg::CH_BITS];
         sat   = (q > (rbu_pkg::CH_BITS+2)'(rbu_pkg::CH_MAX)) ? rbu_pkg::CH_MAX
                                                              : q[rbu_pkg::CH_BITS-1:0];
         blend = (sat & prod_ff.mask) | (d & ~prod_ff.mask);
         result.color[ch] = (prod_ff.chan[ch].op == rbu_pkg::OP_KEEP) ? d : blend;
      end
   end

   // result queue
   always_comb begin
      wr_ptr_in = out_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = out_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (out_push && !out_pop) begin
         count_in = count_ff + 1'b1;
      end else if (out_pop && !out_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

// ===== design/rgba_blend_unit.sv =====
// a request passes through the request queue, the product register and the result queue
// throughput: one fragment per cycle while req_full is low, bounded by the 2x8x8 multiplier stage per channel
// a two-entry queue decouples classification from blending; a two-entry result queue
// lets requests keep flowing while a result waits to be popped
// synchronous active-high reset empties both queues and restores register defaults
module rgba_blend_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rbu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rbu_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [7:0]                        req_write_mask,
   input  logic [7:0]                        req_src_red,
   input  logic [7:0]                        req_src_green,
   input  logic [7:0]                        req_src_blue,
   input  logic [7:0]                        req_src_alpha,
   input  logic [7:0]                        req_dst_red,
   input  logic [7:0]                        req_dst_green,
   input  logic [7:0]                        req_dst_blue,
   input  logic [7:0]                        req_dst_alpha,
   input  logic                              req_last_in,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [7:0]                        rsp_out_red,
   output logic [7:0]                        rsp_out_green,
   output logic [7:0]                        rsp_out_blue,
   output logic [7:0]                        rsp_out_alpha,
   output logic                              rsp_last_out
);

   rbu_pkg::work_type work_in, work_out;
   rbu_pkg::rsp_type  rsp;
   logic              q_full, q_valid, q_pop;
   logic [rbu_pkg::NUM_CH-1:0][rbu_pkg::CH_BITS-1:0] src, dst;

   assign src      = {req_src_alpha, req_src_blue, req_src_green, req_src_red};
   assign dst      = {req_dst_alpha, req_dst_blue, req_dst_green, req_dst_red};
   assign req_full = q_full;

   rbu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .write_mask (req_write_mask),
      .src        (src),
      .dst        (dst),
      .last_in    (req_last_in),
      .work       (work_in)
   );

   rbu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (work_in),
      .full      (q_full),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_data  (work_out)
   );

   rbu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (q_valid),
      .work       (work_out),
      .work_pop   (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp)
   );

   assign rsp_out_red   = rsp.color[0];
   assign rsp_out_green = rsp.color[1];
   assign rsp_out_blue  = rsp.color[2];
   assign rsp_out_alpha = rsp.color[3];
   assign rsp_last_out  = rsp.last;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import rbu_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS = 200;
   localparam logic [3:0] FACTOR_NONE = 4'hF;

   typedef struct packed {
      logic [CH_BITS-1:0]             mask;
      logic [NUM_CH-1:0][CH_BITS-1:0] src;
      logic [NUM_CH-1:0][CH_BITS-1:0] dst;
      logic                           last;
   } fragment_type;

   typedef struct {
      cfg_type      cfg;
      fragment_type frag;
      bit           use_lit;
      rsp_type      lit;
   } vector_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [7:0]             req_write_mask = '0;
   logic [7:0]             req_src_red = '0;
   logic [7:0]             req_src_green = '0;
   logic [7:0]             req_src_blue = '0;
   logic [7:0]             req_src_alpha = '0;
   logic [7:0]             req_dst_red = '0;
   logic [7:0]             req_dst_green = '0;
   logic [7:0]             req_dst_blue = '0;
   logic [7:0]             req_dst_alpha = '0;
   logic                   req_last_in = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [7:0]             rsp_out_red;
   logic [7:0]             rsp_out_green;
   logic [7:0]             rsp_out_blue;
   logic [7:0]             rsp_out_alpha;
   logic                   rsp_last_out;

   cfg_type     blend_cfg = CFG_RESET;
   rsp_type     pending_pixels[$];
   vector_type  directed_rows[$];
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   bit          flood_phase = 1'b0;
   string       chan_name[NUM_CH] = '{"red", "green", "blue", "alpha"};

   rgba_blend_unit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_write_mask (req_write_mask),
      .req_src_red    (req_src_red),
      .req_src_green  (req_src_green),
      .req_src_blue   (req_src_blue),
      .req_src_alpha  (req_src_alpha),
      .req_dst_red    (req_dst_red),
      .req_dst_green  (req_dst_green),
      .req_dst_blue   (req_dst_blue),
      .req_dst_alpha  (req_dst_alpha),
      .req_last_in    (req_last_in),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha),
      .rsp_last_out   (rsp_last_out)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [7:0] blend_weight(input logic [3:0] mode, input int ch,
                                               input logic [NUM_CH-1:0][7:0] s,
                                               input logic [NUM_CH-1:0][7:0] d,
                                               input logic [NUM_CH-1:0][7:0] k);
      logic [7:0] w;
      logic [7:0] room;
      room = 8'hFF - d[ALPHA_CH];
      case (mode)
         FACTOR_ZERO:              w = 8'h00;
         FACTOR_ONE:               w = 8'hFF;
         FACTOR_SRC_COLOR:         w = s[ch];
         FACTOR_ONE_MINUS_SRC:     w = 8'hFF - s[ch];
         FACTOR_DST_COLOR:         w = d[ch];
         FACTOR_ONE_MINUS_DST:     w = 8'hFF - d[ch];
         FACTOR_SRC_ALPHA:         w = s[ALPHA_CH];
         FACTOR_ONE_MINUS_SRC_A:   w = 8'hFF - s[ALPHA_CH];
         FACTOR_DST_ALPHA:         w = d[ALPHA_CH];
         FACTOR_ONE_MINUS_DST_A:   w = 8'hFF - d[ALPHA_CH];
         FACTOR_CONST_COLOR:       w = k[ch];
         FACTOR_ONE_MINUS_CONST:   w = 8'hFF - k[ch];
         FACTOR_CONST_ALPHA:       w = k[ALPHA_CH];
         FACTOR_ONE_MINUS_CONST_A: w = 8'hFF - k[ALPHA_CH];
         FACTOR_SRC_ALPHA_SATURATE: begin
            if (ch == ALPHA_CH) w = 8'hFF;
            else w = (room < s[ALPHA_CH]) ? room : s[ALPHA_CH];
         end
         default:                  w = 8'h00;
      endcase
      return w;
   endfunction

   function automatic rsp_type blend_fragment(input cfg_type c, input fragment_type f);
      rsp_type                    r;
      logic [NUM_CH-1:0][7:0]     k;
      logic [1:0]                 eq;
      logic [3:0]                 s_mode;
      logic [3:0]                 d_mode;
      logic [15:0]                sp;
      logic [15:0]                dp;
      logic [16:0]                x;
      logic [7:0]                 v;
      k = c.blend_constant;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         eq = (ch == ALPHA_CH) ? c.alpha_equation : c.rgb_equation;
         s_mode = (ch == ALPHA_CH) ? c.src_alpha_factor : c.src_rgb_factor;
         d_mode = (ch == ALPHA_CH) ? c.dst_alpha_factor : c.dst_rgb_factor;
         sp = f.src[ch] * blend_weight(s_mode, ch, f.src, f.dst, k);
         dp = f.dst[ch] * blend_weight(d_mode, ch, f.src, f.dst, k);
         r.color[ch] = f.dst[ch];
         if (c.channel_enables[ch] && eq != OP_KEEP) begin
            case (eq)
               EQ_ADD:  x = sp + dp;
               EQ_SUB:  x = (sp > dp) ? sp - dp : 17'd0;
               default: x = (dp > sp) ? dp - sp : 17'd0;
            endcase
            x = (x + 17'd1 + (x >> 8)) >> 8;
            v = (x > 17'd255) ? 8'hFF : x[7:0];
            r.color[ch] = (v & f.mask) | (f.dst[ch] & ~f.mask);
         end
      end
      r.last = f.last;
      return r;
   endfunction

   function automatic cfg_type make_cfg(input logic [1:0] eq_rgb, input logic [1:0] eq_alpha,
                                        input logic [3:0] s_rgb, input logic [3:0] s_alpha,
                                        input logic [3:0] d_rgb, input logic [3:0] d_alpha,
                                        input logic [31:0] konst, input logic [3:0] en);
      cfg_type c;
      c.rgb_equation = eq_rgb;
      c.alpha_equation = eq_alpha;
      c.src_rgb_factor = s_rgb;
      c.src_alpha_factor = s_alpha;
      c.dst_rgb_factor = d_rgb;
      c.dst_alpha_factor = d_alpha;
      c.blend_constant = konst;
      c.channel_enables = en;
      return c;
   endfunction

   function automatic void add_row(input cfg_type c, input logic [7:0] m,
                                   input logic [31:0] s, input logic [31:0] d,
                                   input logic last, input bit use_lit,
                                   input logic [31:0] lit);
      vector_type v;
      v.cfg = c;
      v.frag.mask = m;
      v.frag.src = s;
      v.frag.dst = d;
      v.frag.last = last;
      v.use_lit = use_lit;
      v.lit.color = lit;
      v.lit.last = last;
      directed_rows.push_back(v);
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic fragment_type random_fragment();
      fragment_type f;
      f.mask = ($urandom_range(0, 3) == 0) ? rand_byte() : 8'hFF;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         f.src[ch] = rand_byte();
         f.dst[ch] = rand_byte();
      end
      f.last = 1'($urandom_range(0, 1));
      return f;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.rgb_equation = ($urandom_range(0, 9) == 0) ? OP_KEEP : 2'($urandom_range(0, 2));
      c.alpha_equation = ($urandom_range(0, 9) == 0) ? OP_KEEP : 2'($urandom_range(0, 2));
      c.src_rgb_factor = 4'($urandom_range(0, 15));
      c.src_alpha_factor = 4'($urandom_range(0, 15));
      c.dst_rgb_factor = 4'($urandom_range(0, 15));
      c.dst_alpha_factor = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
         0:       c.blend_constant = 32'h0000_0000;
         1:       c.blend_constant = 32'hFFFF_FFFF;
         default: c.blend_constant = $urandom();
      endcase
      c.channel_enables = $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15));
      return c;
   endfunction

   // registers follow each csr transfer, upper data bits are ignored
   always @(posedge clock) begin
      if (reset) begin
         blend_cfg <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RGB_EQUATION:     blend_cfg.rgb_equation <= csr_data[1:0];
            CSR_ALPHA_EQUATION:   blend_cfg.alpha_equation <= csr_data[1:0];
            CSR_SRC_RGB_FACTOR:   blend_cfg.src_rgb_factor <= csr_data[3:0];
            CSR_SRC_ALPHA_FACTOR: blend_cfg.src_alpha_factor <= csr_data[3:0];
            CSR_DST_RGB_FACTOR:   blend_cfg.dst_rgb_factor <= csr_data[3:0];
            CSR_DST_ALPHA_FACTOR: blend_cfg.dst_alpha_factor <= csr_data[3:0];
            CSR_BLEND_CONSTANT:   blend_cfg.blend_constant <= csr_data;
            CSR_CHANNEL_ENABLES:  blend_cfg.channel_enables <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.color = {rsp_out_alpha, rsp_out_blue, rsp_out_green, rsp_out_red};
         got.last = rsp_last_out;
         if (pending_pixels.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
         end else begin
            want = pending_pixels.pop_front();
            for (int ch = 0; ch < NUM_CH; ch++) begin
               if (got.color[ch] !== want.color[ch]) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: %s expected %0d actual %0d", $time, chan_name[ch],
                              want.color[ch], got.color[ch]);
               end
            end
            if (got.last !== want.last) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            end
         end
      end
   end

   // receiver: random pop pattern, with long hold-offs that back up the input
   initial begin
      int unsigned kind;
      int unsigned len;
      int unsigned odds;
      bit          held;
      held = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         kind = $urandom_range(0, 9);
         len = $urandom_range(4, 40);
         odds = $urandom_range(1, 3);
         if (flood_phase && !held) begin
            held = 1'b1;
            kind = 0;
            len = 90;
         end else if (kind == 0) begin
            len = $urandom_range(20, 60);
         end
         for (int i = 0; i < len; i++) begin
            if (kind == 0) rsp_pop <= 1'b0;
            else if (kind <= 3) rsp_pop <= 1'b1;
            else rsp_pop <= ($urandom_range(0, 3) < odds);
            @(posedge clock);
         end
      end
   end

   task automatic push_fragment(input fragment_type f, input rsp_type want);
      req_push <= 1'b1;
      req_write_mask <= f.mask;
      req_src_red <= f.src[0];
      req_src_green <= f.src[1];
      req_src_blue <= f.src[2];
      req_src_alpha <= f.src[3];
      req_dst_red <= f.dst[0];
      req_dst_green <= f.dst[1];
      req_dst_blue <= f.dst[2];
      req_dst_alpha <= f.dst[3];
      req_last_in <= f.last;
      do @(posedge clock); while (req_full);
      pending_pixels.push_back(want);
   endtask

   task automatic wait_quiet();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      logic [31:0] field;
      logic [31:0] keep;
      for (int idx = 0; idx < 8; idx++) begin
         case (csr_index_type'(idx))
            CSR_RGB_EQUATION:     begin field = 32'(c.rgb_equation);     keep = 32'h3; end
            CSR_ALPHA_EQUATION:   begin field = 32'(c.alpha_equation);   keep = 32'h3; end
            CSR_SRC_RGB_FACTOR:   begin field = 32'(c.src_rgb_factor);   keep = 32'hF; end
            CSR_SRC_ALPHA_FACTOR: begin field = 32'(c.src_alpha_factor); keep = 32'hF; end
            CSR_DST_RGB_FACTOR:   begin field = 32'(c.dst_rgb_factor);   keep = 32'hF; end
            CSR_DST_ALPHA_FACTOR: begin field = 32'(c.dst_alpha_factor); keep = 32'hF; end
            CSR_BLEND_CONSTANT:   begin field = c.blend_constant;        keep = '1;    end
            default:              begin field = 32'(c.channel_enables);  keep = 32'hF; end
         endcase
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(idx);
         csr_data <= (field & keep) | ($urandom() & ~keep);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      cfg_type      sat_cfg;
      cfg_type      sweep_cfg;
      fragment_type frag;
      rsp_type      want;
      int unsigned  burst;
      int unsigned  gap;
      int unsigned  phase_len;
      int unsigned  sent;
      bit           first;

      sat_cfg = make_cfg(EQ_ADD, EQ_ADD, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE,
                         32'h0, 4'hF);
      add_row(CFG_RESET, 8'hFF, 32'h80402010, 32'h11223344, 1'b1, 1'b1, 32'h80402010);
      add_row(CFG_RESET, 8'h00, 32'h80402010, 32'h11223344, 1'b0, 1'b1, 32'h11223344);
      add_row(CFG_RESET, 8'hA5, 32'h00000000, 32'hFFFFFFFF, 1'b0, 1'b1, 32'h5A5A5A5A);
      add_row(sat_cfg, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF);
      add_row(sat_cfg, 8'hFF, 32'h00000000, 32'h00000000, 1'b0, 1'b1, 32'h00000000);
      // negative results clamp to zero
      add_row(make_cfg(EQ_SUB, EQ_SUB, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE,
                       32'h0, 4'hF),
              8'hFF, 32'h10101010, 32'h20202020, 1'b1, 1'b1, 32'h00000000);
      add_row(make_cfg(EQ_RSUB, EQ_RSUB, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE,
                       32'h0, 4'hF),
              8'hFF, 32'h20202020, 32'h10101010, 1'b0, 1'b1, 32'h00000000);
      // undefined equation code keeps the destination
      add_row(make_cfg(OP_KEEP, EQ_ADD, FACTOR_ONE, FACTOR_ONE, FACTOR_ZERO, FACTOR_ZERO,
                       32'h0, 4'hF),
              8'hFF, 32'h55667788, 32'h11223344, 1'b1, 1'b1, 32'h55223344);
      add_row(make_cfg(EQ_ADD, OP_KEEP, FACTOR_ONE, FACTOR_ONE, FACTOR_ZERO, FACTOR_ZERO,
                       32'h0, 4'hF),
              8'hFF, 32'h55667788, 32'h11223344, 1'b0, 1'b1, 32'h11667788);
      // undefined factor code acts as zero
      add_row(make_cfg(EQ_ADD, EQ_ADD, FACTOR_NONE, FACTOR_NONE, FACTOR_NONE, FACTOR_NONE,
                       32'hFFFFFFFF, 4'hF),
              8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h00000000);
      add_row(make_cfg(EQ_ADD, EQ_ADD, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE,
                       32'hFFFFFFFF, 4'h0),
              8'hFF, 32'hFFFFFFFF, 32'h11223344, 1'b0, 1'b1, 32'h11223344);
      add_row(make_cfg(EQ_SUB, EQ_RSUB, FACTOR_SRC_COLOR, FACTOR_CONST_ALPHA,
                       FACTOR_ONE_MINUS_DST, FACTOR_DST_ALPHA, 32'h80C040FF, 4'b0101),
              8'h3C, 32'hE0B07010, 32'h304080C0, 1'b1, 1'b0, 32'h0);
      // every factor mode, on the source or the destination side, of both equations
      for (int i = 0; i < 8; i++) begin
         sweep_cfg = make_cfg(2'(i % 3), 2'((i + 1) % 3), 4'(i), 4'(i + 7), 4'(14 - i), 4'(i),
                              32'h3C965AC3 + i * 32'h1F2E3D4C, 4'hF);
         add_row(sweep_cfg, (i == 3) ? 8'h96 : 8'hFF, 32'h9F3A61C8 + i * 32'h0B1D2F43,
                 32'h4C71A2E5 + i * 32'h2A3B4C5D, 1'(i), 1'b0, 32'h0);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (i == 0 || directed_rows[i].cfg != blend_cfg) begin
            wait_quiet();
            apply_config(directed_rows[i].cfg);
         end
         frag = directed_rows[i].frag;
         want = directed_rows[i].use_lit ? directed_rows[i].lit : blend_fragment(blend_cfg, frag);
         push_fragment(frag, want);
      end

      first = 1'b1;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_quiet();
         apply_config(random_cfg());
         if (first) flood_phase = 1'b1;
         phase_len = first ? 200 : $urandom_range(30, 150);
         burst = 0;
         for (int n = 0; n < phase_len; n++) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 24);
               gap = (first || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap != 0 && n != 0) begin
                  req_push <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            frag = random_fragment();
            push_fragment(frag, blend_fragment(blend_cfg, frag));
            burst--;
            sent++;
         end
         first = 1'b0;
      end

      wait_quiet();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/rbu_pkg.sv
design/rbu_front.sv
design/rbu_queue.sv
design/rbu_back.sv
design/rgba_blend_unit.sv
sim/tb_top.sv
